// ===== rtl/core/keypad_latch_toggle_engine_defines.svh =====
// Assertion macros for the keypad latch and toggle engine.
`ifndef KEYPAD_LATCH_TOGGLE_ENGINE_DEFINES_SVH
`define KEYPAD_LATCH_TOGGLE_ENGINE_DEFINES_SVH

`ifndef SYNTH
`define KLTE_ASSERT_SAME(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("keypad engine check failed");
`define KLTE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("keypad engine check failed");
`else
`define KLTE_ASSERT_SAME(label, clk, rstn, ante, cons)
`define KLTE_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/core/klte_pkg.sv =====
// Types and constants shared by the keypad latch and toggle engine.
package klte_pkg;

  localparam int unsigned ButtonsDefault = 12;
  localparam int unsigned ButtonsMax     = 12;

  localparam int unsigned KindW    = 3;
  localparam int unsigned FrameIdW = 11;
  localparam int unsigned KeyW     = 12;
  localparam int unsigned IndexW   = 4;
  localparam int unsigned LedCodeW = 4;
  localparam int unsigned NodeIdW  = 7;
  localparam int unsigned ModesW   = 24;
  localparam int unsigned LedWordW = 24;
  localparam int unsigned GreenOfs = 12;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [FrameIdW-1:0] KeyFrameBase = 11'h180;
  localparam logic [FrameIdW-1:0] LedFrameBase = 11'h200;
  localparam logic [NodeIdW-1:0]  NodeIdReset  = 7'h15;

  typedef enum logic [KindW-1:0] {
    KindFrame  = 3'd0,
    KindRead   = 3'd1,
    KindUnlock = 3'd2,
    KindSetLed = 3'd3,
    KindLed    = 3'd4
  } klte_kind_e;

  typedef enum logic [1:0] {
    ModePlain   = 2'd0,
    ModeLatch   = 2'd1,
    ModeToggle  = 2'd2,
    ModeSetOnly = 2'd3
  } klte_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgNodeId     = 2'd0,
    CfgLatchModes = 2'd1
  } klte_cfg_e;

  typedef struct packed {
    logic [KindW-1:0]    kind;
    logic [FrameIdW-1:0] frame_id;
    logic [KeyW-1:0]     key_bits;
    logic [IndexW-1:0]   button_index;
    logic [LedCodeW-1:0] led_code;
    logic                want_batch;
  } klte_item_t;

  typedef struct packed {
    logic                button_value;
    logic [LedCodeW-1:0] led_value;
    logic [LedWordW-1:0] led_word;
    logic [FrameIdW-1:0] led_msg_id;
    logic                frame_taken;
  } klte_result_t;

endpackage

// ===== rtl/core/klte_ifs.sv =====
// Channel interfaces of the keypad engine: input items, results, configuration.
interface klte_in_if;
  import klte_pkg::*;
  logic                valid;
  logic                ready;
  logic [KindW-1:0]    kind;
  logic [FrameIdW-1:0] frame_id;
  logic [KeyW-1:0]     key_bits;
  logic [IndexW-1:0]   button_index;
  logic [LedCodeW-1:0] led_code;
  logic                want_batch;

  modport source (output valid, kind, frame_id, key_bits, button_index, led_code,
                  want_batch, input ready);
  modport sink   (input valid, kind, frame_id, key_bits, button_index, led_code,
                  want_batch, output ready);
endinterface

interface klte_out_if;
  import klte_pkg::*;
  logic                valid;
  logic                ready;
  logic                button_value;
  logic [LedCodeW-1:0] led_value;
  logic [LedWordW-1:0] led_word;
  logic [FrameIdW-1:0] led_msg_id;
  logic                frame_taken;

  modport source (output valid, button_value, led_value, led_word, led_msg_id,
                  frame_taken, input ready);
  modport sink   (input valid, button_value, led_value, led_word, led_msg_id,
                  frame_taken, output ready);
endinterface

interface klte_cfg_if;
  import klte_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [ModesW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/keypad_latch_toggle_engine.sv =====
// Keypad latch and toggle engine: button state, latch modes and led codes.
//
// Channels: in_i takes items (frame, button read, unlock, led set, led read or
// batch), out_o returns exactly one result per item, cfg_i writes node_id
// (index 0) and latch_modes (index 1). All use valid/ready; a transfer
// happens on a rising edge with both high. cfg_i is always ready; the user
// must write it only while no item is in flight; the block does not enforce it.
// An accepted item enters the input register, then moves to the result
// register, from which out_o shows it. Throughput: one item per cycle while
// out_o is not held off; the input and result registers each hold one item,
// and all buttons update in parallel in the logic between them.
// Stall: while out_o is held off, the result register keeps its item and the
// input register may still take one more; in_i.ready then drops until out_o
// drains.
// Reset: rst_ni clears the pipeline, raw keys, button states, toggle arms and
// led codes, sets node_id to 21 and all latch modes to plain.
`include "keypad_latch_toggle_engine_defines.svh"

module keypad_latch_toggle_engine #(
  parameter int unsigned BUTTONS = klte_pkg::ButtonsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  klte_in_if.sink         in_i,
  klte_out_if.source      out_o,
  klte_cfg_if.sink        cfg_i
);
  import klte_pkg::*;

  logic                 s1_valid_q, s1_valid_d;
  klte_item_t           s1_item_q, s1_item_d;
  logic                 s1_adv;
  logic                 out_valid_q, out_valid_d;
  klte_result_t         res_q, res_d;

  logic [NodeIdW-1:0]   node_id_q, node_id_d;
  logic [ModesW-1:0]    modes_q, modes_d;
  logic [BUTTONS-1:0]   raw_q, raw_d;
  logic [BUTTONS-1:0]   held_q, held_d;
  logic [BUTTONS-1:0]   armed_q, armed_d;
  logic [LedCodeW-1:0]  led_q [BUTTONS];
  logic [LedCodeW-1:0]  led_d [BUTTONS];

  logic                 idx_ok;
  logic [BUTTONS-1:0]   hit;
  logic                 match;
  klte_mode_e           mode;

  assign s1_adv     = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign cfg_i.ready = 1'b1;

  assign out_o.valid        = out_valid_q;
  assign out_o.button_value = res_q.button_value;
  assign out_o.led_value    = res_q.led_value;
  assign out_o.led_word     = res_q.led_word;
  assign out_o.led_msg_id   = res_q.led_msg_id;
  assign out_o.frame_taken  = res_q.frame_taken;

  // input register
  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_item_d  = s1_item_q;
    if (in_i.ready) begin
      s1_valid_d = in_i.valid;
      s1_item_d  = '{kind: in_i.kind, frame_id: in_i.frame_id, key_bits: in_i.key_bits,
                     button_index: in_i.button_index, led_code: in_i.led_code,
                     want_batch: in_i.want_batch};
    end
  end

  // configuration
  always_comb begin
    node_id_d = node_id_q;
    modes_d   = modes_q;
    if (cfg_i.valid) begin
      unique case (klte_cfg_e'(cfg_i.index))
        CfgNodeId:     node_id_d = cfg_i.data[NodeIdW-1:0];
        CfgLatchModes: modes_d   = cfg_i.data;
        default:       ;
      endcase
    end
  end

  // item work
  always_comb begin
    raw_d       = raw_q;
    held_d      = held_q;
    armed_d     = armed_q;
    led_d       = led_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    mode        = ModePlain;
    idx_ok      = s1_item_q.button_index < IndexW'(BUTTONS);
    match       = s1_item_q.frame_id == (KeyFrameBase + FrameIdW'(node_id_q));
    for (int i = 0; i < BUTTONS; i++) begin
      hit[i] = idx_ok && (s1_item_q.button_index == IndexW'(i));
    end

    if (s1_adv) begin
      out_valid_d = s1_valid_q;
      res_d       = '0;
      if (s1_valid_q) begin
        unique case (klte_kind_e'(s1_item_q.kind))
          KindFrame: begin
            if (match) begin
              res_d.frame_taken = 1'b1;
              for (int i = 0; i < BUTTONS; i++) begin
                mode = klte_mode_e'(modes_q[2*i +: 2]);
                if (s1_item_q.key_bits[i]) begin
                  raw_d[i] = 1'b1;
                  if (mode != ModeToggle) begin
                    held_d[i] = 1'b1;
                  end else if (!armed_q[i]) begin
                    armed_d[i] = 1'b1;
                    held_d[i]  = !held_q[i];
                  end
                end else begin
                  raw_d[i] = 1'b0;
                  if (mode == ModePlain) begin
                    held_d[i] = 1'b0;
                  end
                  armed_d[i] = 1'b0;
                end
              end
            end
          end
          KindRead: begin
            res_d.button_value = |(held_q & hit);
            for (int i = 0; i < BUTTONS; i++) begin
              if (hit[i] && (klte_mode_e'(modes_q[2*i +: 2]) == ModeLatch)) begin
                held_d[i] = raw_q[i];
              end
            end
          end
          KindUnlock: begin
            held_d = (held_q & ~hit) | (raw_q & hit);
          end
          KindSetLed: begin
            for (int i = 0; i < BUTTONS; i++) begin
              if (hit[i]) begin
                led_d[i] = s1_item_q.led_code;
              end
            end
          end
          KindLed: begin
            if (s1_item_q.want_batch) begin
              for (int i = 0; i < BUTTONS; i++) begin
                res_d.led_word[i]            = led_q[i][0];
                res_d.led_word[GreenOfs + i] = led_q[i][2];
              end
              res_d.led_msg_id = LedFrameBase + FrameIdW'(node_id_q);
            end else begin
              for (int i = 0; i < BUTTONS; i++) begin
                if (hit[i]) begin
                  res_d.led_value = led_q[i];
                end
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      node_id_q   <= NodeIdReset;
      modes_q     <= '0;
      raw_q       <= '0;
      held_q      <= '0;
      armed_q     <= '0;
      for (int i = 0; i < BUTTONS; i++) begin
        led_q[i] <= '0;
      end
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      node_id_q   <= node_id_d;
      modes_q     <= modes_d;
      raw_q       <= raw_d;
      held_q      <= held_d;
      armed_q     <= armed_d;
      led_q       <= led_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_item_q <= s1_item_d;
    res_q     <= res_d;
  end

  `KLTE_ASSERT_SAME(a_armed_needs_raw, clk_i, rst_ni, 1'b1, (armed_q & ~raw_q) == '0)
  `KLTE_ASSERT_SAME(a_full_take_moves, clk_i, rst_ni,
                    in_i.valid && in_i.ready && s1_valid_q, s1_adv)
  `KLTE_ASSERT_SAME(a_frame_result_clean, clk_i, rst_ni, out_valid_q && res_q.frame_taken,
                    res_q.led_msg_id == '0 && res_q.led_word == '0 &&
                    res_q.led_value == '0 && !res_q.button_value)
  `KLTE_ASSERT_NEXT(a_result_from_stage, clk_i, rst_ni, s1_valid_q && s1_adv, out_valid_q)

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the keypad latch and toggle engine.
`timescale 1ns / 1ps

module testbench;
  import klte_pkg::*;

  localparam int NumButtons     = ButtonsDefault;
  localparam int RandomPerPhase = 104;
  localparam int NumPhases      = 7;
  localparam int HoldCycles     = 60;
  localparam int QuietLimit     = 5000;

  logic clk_i = 1'b0;
  logic rst_ni;

  klte_in_if  in_ch ();
  klte_out_if out_ch ();
  klte_cfg_if cfg_ch ();

  keypad_latch_toggle_engine uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // keypad state mirror
  logic [NodeIdW-1:0]  node_cfg;
  logic [ModesW-1:0]   modes_cfg;
  logic [KeyW-1:0]     key_raw;
  logic [KeyW-1:0]     held;
  logic [KeyW-1:0]     armed;
  logic [LedCodeW-1:0] led_mem [NumButtons];

  klte_item_t   pending_items[$];
  klte_result_t expected_results[$];
  klte_item_t   offered;

  int phase_no = 0;
  int send_gap_pct = 0;
  int stall_pct = 0;
  logic hold_on;
  int unsigned node_tab [NumPhases];
  int unsigned modes_tab [NumPhases];
  int send_tab [NumPhases];
  int recv_tab [NumPhases];

  int items_taken = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int stray_count = 0;
  int quiet_cycles = 0;

  function automatic klte_result_t keypad_step(klte_item_t it);
    klte_result_t r;
    klte_mode_e   md;
    logic         ok;
    r  = '0;
    ok = (it.button_index < NumButtons);
    case (it.kind)
      KindFrame: begin
        if (it.frame_id == KeyFrameBase + {4'b0, node_cfg}) begin
          r.frame_taken = 1'b1;
          for (int i = 0; i < NumButtons; i++) begin
            md = klte_mode_e'(modes_cfg[2*i +: 2]);
            if (it.key_bits[i]) begin
              key_raw[i] = 1'b1;
              if (md != ModeToggle) begin
                held[i] = 1'b1;
              end else if (!armed[i]) begin
                armed[i] = 1'b1;
                held[i]  = ~held[i];
              end
            end else begin
              key_raw[i] = 1'b0;
              if (md == ModePlain) held[i] = 1'b0;
              armed[i] = 1'b0;
            end
          end
        end
      end
      KindRead: begin
        if (ok) begin
          r.button_value = held[it.button_index];
          md = klte_mode_e'(modes_cfg[2*it.button_index +: 2]);
          if (md == ModeLatch) held[it.button_index] = key_raw[it.button_index];
        end
      end
      KindUnlock: begin
        if (ok) held[it.button_index] = key_raw[it.button_index];
      end
      KindSetLed: begin
        if (ok) led_mem[it.button_index] = it.led_code;
      end
      KindLed: begin
        if (it.want_batch) begin
          for (int i = 0; i < NumButtons; i++) begin
            r.led_word[i]          = led_mem[i][0];
            r.led_word[GreenOfs+i] = led_mem[i][2];
          end
          r.led_msg_id = LedFrameBase + {4'b0, node_cfg};
        end else if (ok) begin
          r.led_value = led_mem[it.button_index];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic klte_item_t build(logic [KindW-1:0] k, logic [FrameIdW-1:0] fid,
                                       logic [KeyW-1:0] keys, logic [IndexW-1:0] idx,
                                       logic [LedCodeW-1:0] code, logic batch);
    klte_item_t it;
    it.kind         = k;
    it.frame_id     = fid;
    it.key_bits     = keys;
    it.button_index = idx;
    it.led_code     = code;
    it.want_batch   = batch;
    return it;
  endfunction

  function automatic klte_item_t random_item();
    klte_item_t  it;
    logic [63:0] rnd;
    int          pick;
    rnd  = {$urandom, $urandom};
    it   = rnd[$bits(klte_item_t)-1:0];
    pick = $urandom_range(99);
    if (pick < 42) begin
      it.kind = KindFrame;
      if ($urandom_range(9) < 8) it.frame_id = KeyFrameBase + {4'b0, node_cfg};
      if ($urandom_range(9) < 2) it.key_bits = 12'(1 << $urandom_range(11));
    end else if (pick < 62) begin
      it.kind = KindRead;
    end else if (pick < 70) begin
      it.kind = KindUnlock;
    end else if (pick < 80) begin
      it.kind = KindSetLed;
    end else if (pick < 95) begin
      it.kind = KindLed;
    end else begin
      it.kind = 3'($urandom_range(7, 5));
    end
    if (it.kind != KindFrame && $urandom_range(9) > 1)
      it.button_index = 4'($urandom_range(NumButtons - 1));
    return it;
  endfunction

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(klte_cfg_e idx, logic [ModesW-1:0] val);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    case (idx)
      CfgNodeId:     node_cfg = val[NodeIdW-1:0];
      CfgLatchModes: modes_cfg = val;
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_phase(int p);
    @(negedge clk_i);
    phase_no     = p;
    send_gap_pct = send_tab[p];
    stall_pct    = recv_tab[p];
  endtask

  // input driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(keypad_step(offered));
        items_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          offered = pending_items.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.kind         <= offered.kind;
          in_ch.frame_id     <= offered.frame_id;
          in_ch.key_bits     <= offered.key_bits;
          in_ch.button_index <= offered.button_index;
          in_ch.led_code     <= offered.led_code;
          in_ch.want_batch   <= offered.want_batch;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin : result_check
    klte_result_t got;
    klte_result_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.button_value = out_ch.button_value;
        got.led_value    = out_ch.led_value;
        got.led_word     = out_ch.led_word;
        got.led_msg_id   = out_ch.led_msg_id;
        got.frame_taken  = out_ch.frame_taken;
        if (expected_results.size() == 0) begin
          stray_count++;
          if (mismatch_count + stray_count <= 10)
            $display("unexpected result: bv=%0d lv=%h word=%h msg=%h taken=%0d",
                     got.button_value, got.led_value, got.led_word, got.led_msg_id,
                     got.frame_taken);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count + stray_count <= 10)
              $display({"mismatch at result %0d: exp bv=%0d lv=%h word=%h msg=%h taken=%0d",
                        " | got bv=%0d lv=%h word=%h msg=%h taken=%0d"},
                       results_checked, want.button_value, want.led_value, want.led_word,
                       want.led_msg_id, want.frame_taken, got.button_value, got.led_value,
                       got.led_word, got.led_msg_id, got.frame_taken);
          end
        end
      end
      out_ch.ready <= !hold_on && ($urandom_range(99) >= stall_pct);
    end
  end

  // long receiver hold-off to back up the pipeline
  initial begin : receiver_hold
    hold_on = 1'b0;
    wait (phase_no == 1);
    @(posedge clk_i);
    hold_on <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("timeout after %0d cycles without progress", quiet_cycles);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    rst_ni             = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.kind         = KindFrame;
    in_ch.frame_id     = '0;
    in_ch.key_bits     = '0;
    in_ch.button_index = '0;
    in_ch.led_code     = '0;
    in_ch.want_batch   = 1'b0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = CfgNodeId;
    cfg_ch.data        = '0;

    node_cfg  = NodeIdReset;
    modes_cfg = '0;
    key_raw   = '0;
    held      = '0;
    armed     = '0;
    for (int i = 0; i < NumButtons; i++) led_mem[i] = '0;

    node_tab  = '{21, 0, 127, $urandom_range(127), $urandom_range(127), 21,
                  $urandom_range(127)};
    modes_tab = '{32'hE4E4E4, 32'h000000, 32'hFFFFFF, 32'h555555, 32'hAAAAAA,
                  $urandom_range(24'hFFFFFF), $urandom_range(24'hFFFFFF)};
    send_tab  = '{0, 0, 81, 0, 9, 0, 9};
    recv_tab  = '{0, 0, 0, 81, 9, 0, 9};

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // node id stays at its reset value; button i gets mode i mod 4
    write_reg(CfgLatchModes, ModesW'(modes_tab[0]));
    set_phase(0);
    pending_items.push_back(build(KindFrame, 11'h195, 12'hFFF, 4'd0, 4'd0, 1'b0));
    pending_items.push_back(build(KindFrame, 11'h194, 12'h000, 4'd0, 4'd0, 1'b0));
    pending_items.push_back(build(KindFrame, 11'h7FF, 12'hFFF, 4'hF, 4'hF, 1'b1));
    pending_items.push_back(build(KindFrame, 11'h000, 12'h000, 4'd0, 4'd0, 1'b0));
    pending_items.push_back(build(KindFrame, 11'h195, 12'h000, 4'd0, 4'd0, 1'b0));
    pending_items.push_back(build(KindRead, 11'h000, 12'h000, 4'd0, 4'd0, 1'b0));
    pending_items.push_back(build(KindRead, 11'h7FF, 12'hFFF, 4'd1, 4'hF, 1'b1));
    pending_items.push_back(build(KindRead, 11'h000, 12'h000, 4'd1, 4'd0, 1'b0));
    pending_items.push_back(build(KindRead, 11'h000, 12'h000, 4'd2, 4'd0, 1'b0));
    pending_items.push_back(build(KindRead, 11'h000, 12'h000, 4'd3, 4'd0, 1'b0));
    pending_items.push_back(build(KindRead, 11'h000, 12'h000, 4'd3, 4'd0, 1'b0));
    pending_items.push_back(build(KindUnlock, 11'h000, 12'h000, 4'd3, 4'd0, 1'b0));
    pending_items.push_back(build(KindRead, 11'h000, 12'h000, 4'd3, 4'd0, 1'b0));
    pending_items.push_back(build(KindRead, 11'h000, 12'h000, 4'd15, 4'd0, 1'b0));
    pending_items.push_back(build(KindUnlock, 11'h000, 12'h000, 4'd13, 4'd0, 1'b0));
    pending_items.push_back(build(KindSetLed, 11'h000, 12'h000, 4'd0, 4'hF, 1'b0));
    pending_items.push_back(build(KindSetLed, 11'h000, 12'h000, 4'd11, 4'h5, 1'b0));
    pending_items.push_back(build(KindSetLed, 11'h000, 12'h000, 4'd14, 4'hF, 1'b0));
    pending_items.push_back(build(KindLed, 11'h000, 12'h000, 4'd0, 4'd0, 1'b0));
    pending_items.push_back(build(KindLed, 11'h000, 12'h000, 4'd11, 4'd0, 1'b0));
    pending_items.push_back(build(KindLed, 11'h000, 12'h000, 4'd12, 4'd0, 1'b0));
    pending_items.push_back(build(KindLed, 11'h000, 12'h000, 4'd15, 4'd0, 1'b1));
    pending_items.push_back(build(3'd5, 11'h195, 12'hFFF, 4'd1, 4'hF, 1'b1));
    pending_items.push_back(build(3'd6, 11'h195, 12'hFFF, 4'd2, 4'hF, 1'b1));
    pending_items.push_back(build(3'd7, 11'h000, 12'h000, 4'd0, 4'd0, 1'b0));

    for (int p = 1; p < NumPhases; p++) begin
      wait_idle();
      write_reg(CfgNodeId, ModesW'(node_tab[p]));
      write_reg(CfgLatchModes, ModesW'(modes_tab[p]));
      set_phase(p);
      for (int n = 0; n < RandomPerPhase; n++) pending_items.push_back(random_item());
    end

    wait_idle();
    repeat (4) @(posedge clk_i);
    $display("%0d items over %0d phases: node ids 0, 21, 127 and random; plain, latching,",
             items_taken, NumPhases);
    $display("toggling, set-only and mixed modes; %0d results checked, %0d bad, %0d stray",
             results_checked, mismatch_count, stray_count);
    if (mismatch_count == 0 && stray_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
